// ===== rtl/core/skvb_pkg.sv =====
// shared types, constants and register codes for the shape key vertex blend
package skvb_pkg;

  // coordinate and weight formats
  localparam int CoordBits  = 16;
  localparam int NumKeys    = 3;
  localparam int WeightBits = 16;
  localparam int FracBits   = 16;

  // blend fraction t is unsigned Q1.16, at most 1.0
  localparam int TBits    = FracBits + 1;
  // weight sum and divider remainder
  localparam int SumBits  = WeightBits + 2;
  localparam int RemBits  = SumBits + 1;
  localparam int CntBits  = $clog2(TBits);
  localparam int KeyBits  = $clog2(NumKeys);
  // product of a signed difference and a zero-extended fraction
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = DiffBits + TBits + 1;
  localparam int StepBits = ProdBits - FracBits;

  // configuration port
  localparam int AddrBits = 4;
  localparam int DataBits = 32;

  typedef logic [CoordBits-1:0]  coord_t;
  typedef coord_t [2:0]          vec_t;
  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [TBits-1:0]      frac_t;

  typedef enum logic [1:0] {
    REG_WEIGHT_A = 2'd0,
    REG_WEIGHT_B = 2'd1,
    REG_WEIGHT_C = 2'd2
  } reg_idx_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  // status of the fraction unit
  typedef struct packed {
    logic busy;
    logic sum_zero;
  } div_status_t;

  // input word
  typedef struct packed {
    logic signed [CoordBits-1:0] basis_x;
    logic signed [CoordBits-1:0] basis_y;
    logic signed [CoordBits-1:0] basis_z;
    logic signed [CoordBits-1:0] key_a_x;
    logic signed [CoordBits-1:0] key_a_y;
    logic signed [CoordBits-1:0] key_a_z;
    logic signed [CoordBits-1:0] key_b_x;
    logic signed [CoordBits-1:0] key_b_y;
    logic signed [CoordBits-1:0] key_b_z;
    logic signed [CoordBits-1:0] key_c_x;
    logic signed [CoordBits-1:0] key_c_y;
    logic signed [CoordBits-1:0] key_c_z;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
  } out_word_t;

  // data handed from cell to cell: current vertex, basis, keys still to apply
  typedef struct packed {
    vec_t                cur;
    vec_t                basis;
    vec_t [NumKeys-1:0]  keys;
  } link_t;

endpackage

// ===== rtl/core/skvb_frac_div.sv =====
// restoring divider that turns the three weights into blend fractions
module skvb_frac_div
  import skvb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  weight_t [NumKeys-1:0]      weight_i,
  output frac_t   [NumKeys-1:0]      frac_o,
  output div_status_t                status_o
);

  div_state_e             state_q, state_d;
  logic                   start_q;
  logic [KeyBits-1:0]     key_q, key_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic [RemBits-1:0]     rem_q, rem_d;
  logic [TBits-2:0]       quo_q, quo_d;
  frac_t [NumKeys-1:0]    frac_q, frac_d;

  logic [SumBits-1:0]     wsum;
  logic                   sum_zero;
  logic                   ge;
  logic [RemBits-1:0]     rem_keep;
  logic [KeyBits-1:0]     key_nxt;

  // sum of all weights
  assign wsum = SumBits'(weight_i[0]) + SumBits'(weight_i[1]) + SumBits'(weight_i[2]);
  assign sum_zero = (wsum == '0);

  // one quotient bit per cycle
  assign ge       = (rem_q >= RemBits'(wsum));
  assign rem_keep = ge ? (rem_q - RemBits'(wsum)) : rem_q;
  assign key_nxt  = key_q + KeyBits'(1);

  // state register; start is registered so the new weight is in place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      start_q <= 1'b0;
      key_q   <= '0;
      cnt_q   <= '0;
      frac_q  <= '0;
    end else begin
      state_q <= state_d;
      start_q <= start_i;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
      frac_q  <= frac_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // next state: seventeen steps per key, keys in order
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    frac_d  = frac_q;
    if (start_q) begin
      state_d = DIV_RUN;
      key_d   = '0;
      cnt_d   = CntBits'(TBits - 1);
      rem_d   = RemBits'(weight_i[0]);
      quo_d   = '0;
    end else begin
      case (state_q)
        DIV_IDLE: begin
          state_d = DIV_IDLE;
        end
        DIV_RUN: begin
          rem_d = {rem_keep[RemBits-2:0], 1'b0};
          quo_d = {quo_q[TBits-3:0], ge};
          if (cnt_q == '0) begin
            frac_d[key_q] = sum_zero ? '0 : {quo_q, ge};
            if (key_q == KeyBits'(NumKeys - 1)) begin
              state_d = DIV_IDLE;
            end else begin
              key_d = key_nxt;
              cnt_d = CntBits'(TBits - 1);
              rem_d = RemBits'(weight_i[key_nxt]);
              quo_d = '0;
            end
          end else begin
            cnt_d = cnt_q - CntBits'(1);
          end
        end
        default: begin
          state_d = DIV_IDLE;
        end
      endcase
    end
  end

  assign frac_o            = frac_q;
  assign status_o.busy     = (state_q == DIV_RUN) || start_q;
  assign status_o.sum_zero = sum_zero;

endmodule

// ===== rtl/core/skvb_cell.sv =====
// one blend cell: moves the vertex toward the first pending key, two stages
module skvb_cell
  import skvb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  frac_t  frac_i,
  input  logic   up_valid_i,
  input  link_t  up_data_i,
  output logic   up_ready_o,
  output logic   dn_valid_o,
  output link_t  dn_data_o,
  input  logic   dn_ready_i
);

  logic                        a_valid_q, b_valid_q;
  link_t                       a_link_q, b_link_q, b_link_d;
  logic signed [ProdBits-1:0]  a_prod_q [3];
  logic signed [ProdBits-1:0]  a_prod_d [3];
  logic                        a_ready, b_ready;

  logic [DiffBits-1:0]         dif [3];
  logic                        differs;
  logic signed [TBits:0]       t_s;
  logic signed [ProdBits-1:0]  rnd [3];
  logic [StepBits-1:0]         step [3];
  logic [StepBits-1:0]         cur_ext [3];
  logic [StepBits-1:0]         moved [3];

  // flow control: a stage takes a word when empty or when it drains
  assign b_ready    = !b_valid_q || dn_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign up_ready_o = a_ready;

  // stage a: difference to key, gated fraction, product
  always_comb begin
    differs = 1'b0;
    for (int c = 0; c < 3; c++) begin
      dif[c] = {up_data_i.keys[0][c][CoordBits-1], up_data_i.keys[0][c]}
             - {up_data_i.cur[c][CoordBits-1], up_data_i.cur[c]};
      if (up_data_i.keys[0][c] != up_data_i.basis[c]) begin
        differs = 1'b1;
      end
    end
    t_s = differs ? $signed({1'b0, frac_i}) : '0;
    for (int c = 0; c < 3; c++) begin
      a_prod_d[c] = $signed(dif[c]) * t_s;
    end
  end

  // stage b: round half up, add, saturate, drop the used key
  always_comb begin
    b_link_d = a_link_q;
    for (int c = 0; c < 3; c++) begin
      rnd[c]     = a_prod_q[c] + ProdBits'(1 << (FracBits - 1));
      step[c]    = rnd[c][ProdBits-1:FracBits];
      cur_ext[c] = {{(StepBits - CoordBits){a_link_q.cur[c][CoordBits-1]}}, a_link_q.cur[c]};
      moved[c]   = cur_ext[c] + step[c];
      if (moved[c][StepBits-1:CoordBits-1] == '0
          || moved[c][StepBits-1:CoordBits-1] == '1) begin
        b_link_d.cur[c] = moved[c][CoordBits-1:0];
      end else if (moved[c][StepBits-1]) begin
        b_link_d.cur[c] = {1'b1, {(CoordBits - 1){1'b0}}};
      end else begin
        b_link_d.cur[c] = {1'b0, {(CoordBits - 1){1'b1}}};
      end
    end
    for (int k = 0; k < NumKeys - 1; k++) begin
      b_link_d.keys[k] = a_link_q.keys[k + 1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= up_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (a_ready && up_valid_i) begin
      a_link_q <= up_data_i;
      for (int c = 0; c < 3; c++) begin
        a_prod_q[c] <= a_prod_d[c];
      end
    end
    if (b_ready && a_valid_q) begin
      b_link_q <= b_link_d;
    end
  end

  assign dn_valid_o = b_valid_q;
  assign dn_data_o  = b_link_q;

endmodule

// ===== rtl/core/shape_key_vertex_blend_top.sv =====
// top level of the shape key vertex blend: config registers, fraction unit, cell chain
//
// Blends one vertex per word: the basis position moves toward shape keys a, b and c
// in turn, each by its weight over the sum of all weights, and the result is
// saturated to 16 bits.
// Input channel in_valid_i / in_stall_o / in_word_i carries basis and key positions;
// output channel out_valid_o / out_stall_i / out_word_o carries the blended x, y, z.
// Weights are written over the APB-style port at byte addresses 0, 4 and 8.
// From acceptance to out_valid_o a word passes a chain of three cells, one per key,
// each with a multiply stage and a round-and-add stage. Throughput is one word per
// cycle, set by the cell chain, while the divider is idle and out_stall_i is low.
// After any weight write the fraction unit recomputes the three fractions with a
// one bit per cycle divider: a load step, then the quotient bits of each key in turn;
// in_stall_o is high while it runs.
// Reset clears all weights to zero; words are taken from the first cycle after it.
// When the receiver stalls, the last cell holds its word and the chain keeps
// filling its empty stages, so inputs are still taken until every stage is full.
module shape_key_vertex_blend_top
  import skvb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrBits-1:0]  paddr,
  input  logic [DataBits-1:0]  pwdata,
  output logic [DataBits-1:0]  prdata,
  output logic                 pready
);

  weight_t [NumKeys-1:0]   weight_q;
  frac_t   [NumKeys-1:0]   frac;
  div_status_t             div_status;
  logic                    wr_en;
  logic                    wr_hit;
  reg_idx_e                reg_idx;

  logic  [NumKeys:0]       chain_valid;
  logic  [NumKeys:0]       chain_ready;
  link_t                   chain_data [NumKeys+1];

  // register access decode
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[AddrBits-1:2]);

  always_comb begin
    case (reg_idx)
      REG_WEIGHT_A: wr_hit = 1'b1;
      REG_WEIGHT_B: wr_hit = 1'b1;
      REG_WEIGHT_C: wr_hit = 1'b1;
      default:      wr_hit = 1'b0;
    endcase
  end

  // weight registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WEIGHT_A: weight_q[REG_WEIGHT_A] <= pwdata[WeightBits-1:0];
        REG_WEIGHT_B: weight_q[REG_WEIGHT_B] <= pwdata[WeightBits-1:0];
        REG_WEIGHT_C: weight_q[REG_WEIGHT_C] <= pwdata[WeightBits-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_WEIGHT_A: prdata = DataBits'(weight_q[REG_WEIGHT_A]);
      REG_WEIGHT_B: prdata = DataBits'(weight_q[REG_WEIGHT_B]);
      REG_WEIGHT_C: prdata = DataBits'(weight_q[REG_WEIGHT_C]);
      default:      prdata = '0;
    endcase
  end

  // fraction unit, restarted by every weight write
  skvb_frac_div u_frac_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wr_en && wr_hit),
    .weight_i (weight_q),
    .frac_o   (frac),
    .status_o (div_status)
  );

  // input word into the chain: vertex starts at the basis
  assign chain_valid[0]             = in_valid_i && !div_status.busy;
  assign chain_data[0].cur[2]       = in_word_i.basis_x;
  assign chain_data[0].cur[1]       = in_word_i.basis_y;
  assign chain_data[0].cur[0]       = in_word_i.basis_z;
  assign chain_data[0].basis[2]     = in_word_i.basis_x;
  assign chain_data[0].basis[1]     = in_word_i.basis_y;
  assign chain_data[0].basis[0]     = in_word_i.basis_z;
  assign chain_data[0].keys[0][2]   = in_word_i.key_a_x;
  assign chain_data[0].keys[0][1]   = in_word_i.key_a_y;
  assign chain_data[0].keys[0][0]   = in_word_i.key_a_z;
  assign chain_data[0].keys[1][2]   = in_word_i.key_b_x;
  assign chain_data[0].keys[1][1]   = in_word_i.key_b_y;
  assign chain_data[0].keys[1][0]   = in_word_i.key_b_z;
  assign chain_data[0].keys[2][2]   = in_word_i.key_c_x;
  assign chain_data[0].keys[2][1]   = in_word_i.key_c_y;
  assign chain_data[0].keys[2][0]   = in_word_i.key_c_z;
  assign in_stall_o                 = div_status.busy || !chain_ready[0];

  // one cell per key, in key order
  for (genvar k = 0; k < NumKeys; k++) begin : g_cell
    skvb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .frac_i     (frac[k]),
      .up_valid_i (chain_valid[k]),
      .up_data_i  (chain_data[k]),
      .up_ready_o (chain_ready[k]),
      .dn_valid_o (chain_valid[k+1]),
      .dn_data_o  (chain_data[k+1]),
      .dn_ready_i (chain_ready[k+1])
    );
  end

  // last cell output register drives the output channel
  assign chain_ready[NumKeys] = !out_stall_i;
  assign out_valid_o          = chain_valid[NumKeys];
  assign out_word_o.out_x     = chain_data[NumKeys].cur[2];
  assign out_word_o.out_y     = chain_data[NumKeys].cur[1];
  assign out_word_o.out_z     = chain_data[NumKeys].cur[0];

  // no word enters while fractions are being recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.busy |-> in_stall_o)
    else $error("word accepted while fraction unit busy");

  // a weight write always starts a recompute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && wr_hit) |=> div_status.busy)
    else $error("weight write did not start fraction unit");

  // with all weights zero, settled fractions are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!div_status.busy && div_status.sum_zero) |-> (frac == '0))
    else $error("nonzero fraction with zero weight sum");

endmodule
